// ===== hw/rtl/sbre_pkg.sv =====
// Package for the six-bit regroup encoder.
// Holds the held-bit count codes, the regroup result type and the character map.
// No dependencies.
package sbre_pkg;

	// Held-bit count, stored as half the number of held bits.
	localparam logic [1:0] CNT0 = 2'd0;
	localparam logic [1:0] CNT2 = 2'd1;
	localparam logic [1:0] CNT4 = 2'd2;

	localparam logic [7:0] CHAR_UPPER_OFS = 8'd65;
	localparam logic [7:0] CHAR_LOWER_OFS = 8'd71;
	localparam logic [7:0] CHAR_DIGIT_SUB = 8'd4;
	localparam logic [7:0] CHAR_NINE      = 8'd57;

	// Characters produced by one byte, plus the held bits it leaves behind.
	typedef struct packed {
		logic [7:0] char0;
		logic       eom0;
		logic [7:0] char1;
		logic       eom1;
		logic       two;
		logic [3:0] next_bits;
		logic [1:0] next_cnt;
	} regroup_res_t;

	// Maps a six-bit group to its ASCII character.
	function automatic logic [7:0] map_six(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v <= 6'd25) begin
			return w + CHAR_UPPER_OFS;
		end else if (v <= 6'd51) begin
			return w + CHAR_LOWER_OFS;
		end else if (v <= 6'd61) begin
			return w - CHAR_DIGIT_SUB;
		end else begin
			return CHAR_NINE;
		end
	endfunction

endpackage

// ===== hw/rtl/sbre_if.sv =====
// Valid/ready stream interfaces for the six-bit regroup encoder.
// One for input bytes, one for output characters; no dependencies.
interface sbre_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface sbre_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_char;
	logic       end_of_message;

	modport source (output valid, output code_char, output end_of_message, input ready);
	modport sink (input valid, input code_char, input end_of_message, output ready);
endinterface

// ===== hw/rtl/sbre_regroup.sv =====
// Combinational regroup of one byte with the held bits into one or two characters.
// Depends on sbre_pkg.
module sbre_regroup
	import sbre_pkg::*;
(
	input  logic [7:0]   data_byte,
	input  logic         final_byte,
	input  logic [3:0]   pend_bits,
	input  logic [1:0]   pend_cnt,
	output regroup_res_t res
);

	logic [5:0] grp0;
	logic [5:0] grp1;

	always_comb begin
		grp0 = 6'd0;
		grp1 = 6'd0;
		res.two = 1'b0;
		res.next_bits = 4'd0;
		res.next_cnt = CNT0;
		case (pend_cnt)
			CNT0: begin
				grp0 = data_byte[7:2];
				grp1 = {data_byte[1:0], 4'b0000};
				res.two = final_byte;
				res.next_bits = {2'b00, data_byte[1:0]};
				res.next_cnt = CNT2;
			end
			CNT2: begin
				grp0 = {pend_bits[1:0], data_byte[7:4]};
				grp1 = {data_byte[3:0], 2'b00};
				res.two = final_byte;
				res.next_bits = data_byte[3:0];
				res.next_cnt = CNT4;
			end
			default: begin
				// Four bits held: two full groups, nothing left over.
				grp0 = {pend_bits[3:0], data_byte[7:6]};
				grp1 = data_byte[5:0];
				res.two = 1'b1;
				res.next_bits = 4'd0;
				res.next_cnt = CNT0;
			end
		endcase
		if (final_byte) begin
			res.next_bits = 4'd0;
			res.next_cnt = CNT0;
		end
		res.char0 = map_six(grp0);
		res.char1 = map_six(grp1);
		res.eom0 = final_byte & ~res.two;
		res.eom1 = final_byte & res.two;
	end

endmodule

// ===== hw/rtl/six_bit_regroup_encoder.sv =====
// Top level of the six-bit regroup encoder.
// Depends on sbre_pkg, sbre_if.sv (stream interfaces) and sbre_regroup.
//
// Bytes come in on byte_ch, most significant bit first, and leave as a stream
// of ASCII characters on char_ch, six bits to a character in the base64
// alphabet (values 62 and 63 both give '9', and no '=' padding is sent).
// Up to four bits are held between bytes. A byte with final_byte set flushes
// the held bits, zero padded on the right, as one last character, and that
// last character carries end_of_message; the held bits are then cleared for
// the next message. Each accepted item is captured in an input register, then
// regrouped into one or two characters that load a two-entry result buffer;
// the first character of an item shows on char_ch the cycle after it leaves
// the input register. The result port sends one character per cycle while
// char_ch.ready is high, so an item that makes two characters occupies the
// port for both in turn: with the sink always ready the block takes one byte
// per cycle on bytes that make one character, and holds the next byte in the
// input register while the second character of a two-character byte is sent.
// While a finished character waits on char_ch, the input register can still
// take one new item; byte_ch.ready then stays low until the result buffer can take that item.
module six_bit_regroup_encoder
	import sbre_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	sbre_in_if.sink  byte_ch,
	sbre_out_if.source char_ch
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// Result buffer: head character on the port, optional second behind it.
	logic       head_valid_s2;
	logic [7:0] char_s2;
	logic       eom_s2;
	logic       second_valid_s2;
	logic [7:0] char1_s2;
	logic       eom1_s2;

	// Held bits between bytes.
	logic [3:0] pend_bits_q;
	logic [1:0] pend_cnt_q;

	regroup_res_t res;
	logic         out_fire;
	logic         move;
	logic         in_fire;

	sbre_regroup u_regroup (
		.data_byte  (byte_s1),
		.final_byte (final_s1),
		.pend_bits  (pend_bits_q),
		.pend_cnt   (pend_cnt_q),
		.res        (res)
	);

	assign out_fire = head_valid_s2 & char_ch.ready;
	// The buffer takes a new item once its last character is leaving or it is empty.
	assign move = valid_s1 & (~head_valid_s2 | (out_fire & ~second_valid_s2));
	assign in_fire = byte_ch.valid & byte_ch.ready;

	assign byte_ch.ready = ~valid_s1 | move;

	assign char_ch.valid = head_valid_s2;
	assign char_ch.code_char = char_s2;
	assign char_ch.end_of_message = eom_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= byte_ch.data_byte;
			final_s1 <= byte_ch.final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_s2 <= 1'b0;
			second_valid_s2 <= 1'b0;
			pend_bits_q <= 4'd0;
			pend_cnt_q <= CNT0;
		end else if (move) begin
			head_valid_s2 <= 1'b1;
			second_valid_s2 <= res.two;
			pend_bits_q <= res.next_bits;
			pend_cnt_q <= res.next_cnt;
		end else if (out_fire) begin
			head_valid_s2 <= second_valid_s2;
			second_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			char_s2 <= res.char0;
			eom_s2 <= res.eom0;
			char1_s2 <= res.char1;
			eom1_s2 <= res.eom1;
		end else if (out_fire) begin
			char_s2 <= char1_s2;
			eom_s2 <= eom1_s2;
		end
	end

`ifndef ASSERT_OFF
	// A waiting second character always sits behind a valid head.
	a_second_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		second_valid_s2 |-> head_valid_s2)
		else $error("second character buffered without a head character");

	// End of message is only ever on the last character of an item.
	a_eom_last: assert property (@(posedge clk) disable iff (!arst_n)
		second_valid_s2 |-> !eom_s2)
		else $error("end of message on a character that has a follower");

	// A final byte leaves no held bits behind.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(move && final_s1) |=> (pend_cnt_q == CNT0 && pend_bits_q == 4'd0))
		else $error("held bits not cleared after final byte");
`endif

endmodule
